FILE: design/bgw_pkg.sv
// Package for the bilinear grid warp block: lattice sizes, derived widths and codes.
// No dependencies.
package bgw_pkg;

    localparam int GRID_COLS = 11;
    localparam int GRID_ROWS = 3;
    localparam int NPTS      = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W    = $clog2(NPTS);
    localparam int COL_W     = 4;
    localparam int ROW_W     = 2;
    localparam int Q_W       = 13;
    localparam int CRD_W     = 16;
    localparam int OPD_W     = 29;
    localparam int ACC_W     = 42;
    localparam int STEP_W    = 4;
    localparam int DIV_STEPS = 13;
    localparam int MAC_STEPS = 6;
    localparam logic [Q_W-1:0] ONE_Q12 = 13'd4096;

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_LOCATE = 2'd1,
        MODE_INTERP = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_MAC,
        ST_OUT
    } state_t;

endpackage

FILE: design/bilinear_grid_warp.sv
// Bilinear grid warp: lattice store in one dual-read RAM, localize scan and divider,
// bilinear multiply-accumulate. Depends on bgw_pkg.
//
// Usage: a mode-0 beat writes one grid point {x,y} into the lattice RAM in the cycle it
// is accepted and returns nothing; input is ready again on the next cycle. A mode-1 beat
// (localize) scans all cells, one cell per cycle through the RAM's two read ports
// (lower-left and upper-right corner), keeps the last matching cell, then runs a
// 13-step restoring divider for u and v in parallel. A mode-2 beat (interpolate) reads
// the four corners in states RD0, RD1 and RD2, then runs a six-step multiply-accumulate
// per axis. Mode 3 is dropped. One item is in flight at a time; a finished result sits
// in the output register, and a new beat is taken while it waits. Grid points must be
// written before they are read; there is no clearing pass. Writes land before any later
// read starts, so no forwarding is needed.
module bilinear_grid_warp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         mode,
    input  logic [bgw_pkg::COL_W-1:0]          col_index,
    input  logic [bgw_pkg::ROW_W-1:0]          row_index,
    input  logic signed [bgw_pkg::CRD_W-1:0]   coord_x,
    input  logic signed [bgw_pkg::CRD_W-1:0]   coord_y,
    input  logic [bgw_pkg::Q_W-1:0]            u_in,
    input  logic [bgw_pkg::Q_W-1:0]            v_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic [bgw_pkg::COL_W-1:0]          cell_col,
    output logic                               cell_row,
    output logic [bgw_pkg::Q_W-1:0]            frac_u,
    output logic [bgw_pkg::Q_W-1:0]            frac_v,
    output logic signed [bgw_pkg::CRD_W-1:0]   out_x,
    output logic signed [bgw_pkg::CRD_W-1:0]   out_y
);
    import bgw_pkg::*;

    // lattice RAM: {x, y} per grid point
    logic [2*CRD_W-1:0] mem [NPTS];
    logic [2*CRD_W-1:0] rd_a_reg, rd_b_reg;
    logic [ADDR_W-1:0]  addr_a, addr_b, waddr;
    logic               we;

    state_t state_reg, state_next;
    logic   interp_reg, interp_next;
    logic signed [CRD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [COL_W-1:0] c_reg, c_next;
    logic [ROW_W-1:0] r_reg, r_next;
    logic [Q_W-1:0]   u_reg, u_next, v_reg, v_next;
    logic scan_live_reg, scan_live_next, cmp_valid_reg, cmp_valid_next;
    logic [COL_W-1:0] cmp_c_reg, cmp_c_next, hit_c_reg, hit_c_next;
    logic [ROW_W-1:0] cmp_r_reg, cmp_r_next, hit_r_reg, hit_r_next;
    logic hit_reg, hit_next;
    logic [CRD_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [CRD_W-1:0] denx_reg, denx_next, deny_reg, deny_next;
    logic [CRD_W-1:0] remx_reg, remx_next, remy_reg, remy_next;
    logic [Q_W-1:0]   qx_reg, qx_next, qy_reg, qy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [2*CRD_W-1:0] c00_reg, c00_next, c10_reg, c10_next;
    logic [2*CRD_W-1:0] c01_reg, c01_next, c11_reg, c11_next;
    logic signed [ACC_W-1:0] accx_reg, accx_next, accy_reg, accy_next;
    logic signed [OPD_W-1:0] lox_reg, lox_next, loy_reg, loy_next;
    logic signed [OPD_W-1:0] hix_reg, hix_next, hiy_reg, hiy_next;
    logic out_valid_reg, out_valid_next, found_reg, found_next;
    logic [COL_W-1:0] cell_col_reg, cell_col_next;
    logic cell_row_reg, cell_row_next;
    logic [Q_W-1:0] frac_u_reg, frac_u_next, frac_v_reg, frac_v_next;
    logic signed [CRD_W-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;

    // comparison, divider and MAC datapath
    logic signed [CRD_W-1:0] x0, y0, x1, y1;
    logic signed [CRD_W:0]   ddx, ddy, ddnx, ddny;
    logic                    in_box;
    logic [CRD_W:0]          shx, shy;
    logic                    gex, gey;
    logic [Q_W-1:0]          coef;
    logic signed [OPD_W-1:0] opx, opy;
    logic signed [ACC_W-1:0] coef_w, opx_w, opy_w;
    logic signed [ACC_W-1:0] prodx, prody;
    logic [ADDR_W-1:0]       base;

    function automatic logic signed [OPD_W-1:0] sx(input logic [CRD_W-1:0] a);
        sx = {{(OPD_W-CRD_W){a[CRD_W-1]}}, a};
    endfunction

    // floor shift by 24, then saturate to 16 bits
    function automatic logic signed [CRD_W-1:0] sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-25:0] q;
        q = a[ACC_W-1:24];
        if (q > $signed((ACC_W-24)'(32767)))       sat = 16'sh7FFF;
        else if (q < -$signed((ACC_W-24)'(32768))) sat = 16'sh8000;
        else                                        sat = q[CRD_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {coord_x, coord_y};
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign cell_col  = cell_col_reg;
    assign cell_row  = cell_row_reg;
    assign frac_u    = frac_u_reg;
    assign frac_v    = frac_v_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

    assign base = ADDR_W'(r_reg) * ADDR_W'(GRID_COLS) + ADDR_W'(c_reg);
    assign we   = in_valid && in_ready && (mode == MODE_WRITE) &&
                  (col_index < COL_W'(GRID_COLS)) && (row_index < ROW_W'(GRID_ROWS));
    assign waddr = ADDR_W'(row_index) * ADDR_W'(GRID_COLS) + ADDR_W'(col_index);

    assign x0 = rd_a_reg[2*CRD_W-1:CRD_W];
    assign y0 = rd_a_reg[CRD_W-1:0];
    assign x1 = rd_b_reg[2*CRD_W-1:CRD_W];
    assign y1 = rd_b_reg[CRD_W-1:0];
    assign in_box = (x0 <= px_reg) && (px_reg <= x1) && (y0 <= py_reg) && (py_reg <= y1);
    assign ddx  = {px_reg[CRD_W-1], px_reg} - {x0[CRD_W-1], x0};
    assign ddy  = {py_reg[CRD_W-1], py_reg} - {y0[CRD_W-1], y0};
    assign ddnx = {x1[CRD_W-1], x1} - {x0[CRD_W-1], x0};
    assign ddny = {y1[CRD_W-1], y1} - {y0[CRD_W-1], y0};

    // restoring divide: first step takes the dividend unshifted
    assign shx = (step_reg == '0) ? {1'b0, dx_reg} : {remx_reg, 1'b0};
    assign shy = (step_reg == '0) ? {1'b0, dy_reg} : {remy_reg, 1'b0};
    assign gex = shx >= {1'b0, denx_reg};
    assign gey = shy >= {1'b0, deny_reg};

    always_comb
    begin
        unique case (step_reg)
            4'd0:
            begin
                coef = ONE_Q12 - u_reg;
                opx  = sx(c00_reg[2*CRD_W-1:CRD_W]);
                opy  = sx(c00_reg[CRD_W-1:0]);
            end
            4'd1:
            begin
                coef = u_reg;
                opx  = sx(c10_reg[2*CRD_W-1:CRD_W]);
                opy  = sx(c10_reg[CRD_W-1:0]);
            end
            4'd2:
            begin
                coef = ONE_Q12 - u_reg;
                opx  = sx(c01_reg[2*CRD_W-1:CRD_W]);
                opy  = sx(c01_reg[CRD_W-1:0]);
            end
            4'd3:
            begin
                coef = u_reg;
                opx  = sx(c11_reg[2*CRD_W-1:CRD_W]);
                opy  = sx(c11_reg[CRD_W-1:0]);
            end
            4'd4:
            begin
                coef = ONE_Q12 - v_reg;
                opx  = lox_reg;
                opy  = loy_reg;
            end
            default:
            begin
                coef = v_reg;
                opx  = hix_reg;
                opy  = hiy_reg;
            end
        endcase
    end

    // operands widened to the accumulator so the full product is kept
    assign coef_w = ACC_W'($signed({1'b0, coef}));
    assign opx_w  = ACC_W'(opx);
    assign opy_w  = ACC_W'(opy);
    assign prodx  = coef_w * opx_w;
    assign prody  = coef_w * opy_w;

    always_comb
    begin
        state_next = state_reg;     interp_next = interp_reg;
        px_next = px_reg;           py_next = py_reg;
        c_next = c_reg;             r_next = r_reg;
        u_next = u_reg;             v_next = v_reg;
        scan_live_next = scan_live_reg;
        cmp_valid_next = 1'b0;
        cmp_c_next = cmp_c_reg;     cmp_r_next = cmp_r_reg;
        hit_next = hit_reg;         hit_c_next = hit_c_reg;   hit_r_next = hit_r_reg;
        dx_next = dx_reg;           dy_next = dy_reg;
        denx_next = denx_reg;       deny_next = deny_reg;
        remx_next = remx_reg;       remy_next = remy_reg;
        qx_next = qx_reg;           qy_next = qy_reg;
        step_next = step_reg;
        c00_next = c00_reg; c10_next = c10_reg; c01_next = c01_reg; c11_next = c11_reg;
        accx_next = accx_reg;       accy_next = accy_reg;
        lox_next = lox_reg;         loy_next = loy_reg;
        hix_next = hix_reg;         hiy_next = hiy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next = found_reg;     cell_col_next = cell_col_reg;
        cell_row_next = cell_row_reg;
        frac_u_next = frac_u_reg;   frac_v_next = frac_v_reg;
        out_x_next = out_x_reg;     out_y_next = out_y_reg;
        addr_a = base;
        addr_b = base + ADDR_W'(GRID_COLS + 1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    px_next = coord_x;
                    py_next = coord_y;
                    hit_next = 1'b0;
                    hit_c_next = '0;
                    hit_r_next = '0;
                    step_next = '0;
                    if (mode == MODE_LOCATE)
                    begin
                        interp_next = 1'b0;
                        c_next = '0;
                        r_next = '0;
                        scan_live_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else if (mode == MODE_INTERP)
                    begin
                        interp_next = 1'b1;
                        c_next = (col_index > COL_W'(GRID_COLS - 2)) ?
                                 COL_W'(GRID_COLS - 2) : col_index;
                        r_next = (row_index > ROW_W'(GRID_ROWS - 2)) ?
                                 ROW_W'(GRID_ROWS - 2) : row_index;
                        u_next = (u_in > ONE_Q12) ? ONE_Q12 : u_in;
                        v_next = (v_in > ONE_Q12) ? ONE_Q12 : v_in;
                        state_next = ST_RD0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_live_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_c_next = c_reg;
                    cmp_r_next = r_reg;
                    if (r_reg == ROW_W'(GRID_ROWS - 2))
                    begin
                        r_next = '0;
                        if (c_reg == COL_W'(GRID_COLS - 2))
                        begin
                            scan_live_next = 1'b0;
                        end
                        else
                        begin
                            c_next = c_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
                if (cmp_valid_reg && in_box)
                begin
                    hit_next = 1'b1;
                    hit_c_next = cmp_c_reg;
                    hit_r_next = cmp_r_reg;
                    dx_next = ddx[CRD_W-1:0];
                    dy_next = ddy[CRD_W-1:0];
                    denx_next = ddnx[CRD_W-1:0];
                    deny_next = ddny[CRD_W-1:0];
                end
                if (cmp_valid_reg && !scan_live_reg)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                remx_next = gex ? CRD_W'(shx - {1'b0, denx_reg}) : shx[CRD_W-1:0];
                remy_next = gey ? CRD_W'(shy - {1'b0, deny_reg}) : shy[CRD_W-1:0];
                qx_next = {qx_reg[Q_W-2:0], gex};
                qy_next = {qy_reg[Q_W-2:0], gey};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
                addr_b = base + ADDR_W'(1);
            end
            ST_RD1:
            begin
                addr_a = base + ADDR_W'(GRID_COLS);
                c00_next = rd_a_reg;
                c10_next = rd_b_reg;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                c01_next = rd_a_reg;
                c11_next = rd_b_reg;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                accx_next = step_reg[0] ? accx_reg + prodx : prodx;
                accy_next = step_reg[0] ? accy_reg + prody : prody;
                if (step_reg == 4'd2)
                begin
                    lox_next = accx_reg[OPD_W-1:0];
                    loy_next = accy_reg[OPD_W-1:0];
                end
                if (step_reg == 4'd4)
                begin
                    hix_next = accx_reg[OPD_W-1:0];
                    hiy_next = accy_reg[OPD_W-1:0];
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MAC_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                    if (interp_reg)
                    begin
                        found_next = 1'b1;
                        cell_col_next = c_reg;
                        cell_row_next = r_reg[0];
                        frac_u_next = u_reg;
                        frac_v_next = v_reg;
                        out_x_next = sat(accx_reg);
                        out_y_next = sat(accy_reg);
                    end
                    else
                    begin
                        found_next = hit_reg;
                        cell_col_next = hit_c_reg;
                        cell_row_next = hit_r_reg[0];
                        // zero-width cell gives a zero offset
                        frac_u_next = (hit_reg && denx_reg != '0) ? qx_reg : '0;
                        frac_v_next = (hit_reg && deny_reg != '0) ? qy_reg : '0;
                        out_x_next = '0;
                        out_y_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            scan_live_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            scan_live_reg <= scan_live_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        interp_reg <= interp_next;  px_reg <= px_next;  py_reg <= py_next;
        c_reg <= c_next;            r_reg <= r_next;
        u_reg <= u_next;            v_reg <= v_next;
        cmp_c_reg <= cmp_c_next;    cmp_r_reg <= cmp_r_next;
        hit_reg <= hit_next;        hit_c_reg <= hit_c_next;  hit_r_reg <= hit_r_next;
        dx_reg <= dx_next;          dy_reg <= dy_next;
        denx_reg <= denx_next;      deny_reg <= deny_next;
        remx_reg <= remx_next;      remy_reg <= remy_next;
        qx_reg <= qx_next;          qy_reg <= qy_next;
        step_reg <= step_next;
        c00_reg <= c00_next;  c10_reg <= c10_next;  c01_reg <= c01_next;  c11_reg <= c11_next;
        accx_reg <= accx_next;      accy_reg <= accy_next;
        lox_reg <= lox_next;        loy_reg <= loy_next;
        hix_reg <= hix_next;        hiy_reg <= hiy_next;
        found_reg <= found_next;    cell_col_reg <= cell_col_next;
        cell_row_reg <= cell_row_next;
        frac_u_reg <= frac_u_next;  frac_v_reg <= frac_v_next;
        out_x_reg <= out_x_next;    out_y_reg <= out_y_next;
    end

    // offsets never exceed one
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (frac_u_reg <= ONE_Q12) && (frac_v_reg <= ONE_Q12))
        else $error("offset above one");

    // a miss reports a zero cell column, u offset and x result
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |->
        (cell_col_reg == '0) && (frac_u_reg == '0) && (out_x_reg == '0))
        else $error("miss with nonzero fields");

    // scan never issues past the last lattice point
    a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_live_reg) |-> (addr_b < ADDR_W'(NPTS)))
        else $error("scan address out of range");

    // compare stage only runs while scanning
    a_cmp_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> $past(state_reg == ST_SCAN && scan_live_reg))
        else $error("stray compare");

endmodule
